/* hdl/svmhg_pkg.sv */
// svmhg_pkg: shared types and constants for the hinge-gradient accumulator
// no dependencies; imported by the interfaces and every module of the block
package svmhg_pkg;

  // input word lanes carried by one word
  localparam int unsigned LANES      = 8;
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned GRAD_W     = 32;
  localparam int unsigned DOT_W      = PROD_W + 3;
  localparam int unsigned LAMBDA_W   = 16;
  localparam int unsigned USED_W     = 4;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SCALE_SH   = 15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USED_FEATURES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA        = 1'd1;

  // configuration reset values
  localparam logic [USED_W-1:0]   USED_RESET   = 4'd8;
  localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd655;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAIR,
    S_DOT,
    S_UPD,
    S_RMUL,
    S_RSAT,
    S_RWAIT
  } state_e;

  // per-lane controls from the sequencer
  typedef struct packed {
    logic load;
    logic capture;
    logic update;
    logic clear;
    logic sub;
  } lane_ctrl_t;

  // readout controls from the sequencer
  typedef struct packed {
    logic               mul;
    logic               load;
    logic               last;
    logic [INDEX_W-1:0] index;
  } rd_ctrl_t;

endpackage

/* hdl/svmhg_in_if.sv */
// svmhg_in_if: input channel carrying op, label and eight element lanes
// depends on svmhg_pkg
interface svmhg_in_if;
  import svmhg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic                     label_pos;
  logic signed [ELEM_W-1:0] lane0;
  logic signed [ELEM_W-1:0] lane1;
  logic signed [ELEM_W-1:0] lane2;
  logic signed [ELEM_W-1:0] lane3;
  logic signed [ELEM_W-1:0] lane4;
  logic signed [ELEM_W-1:0] lane5;
  logic signed [ELEM_W-1:0] lane6;
  logic signed [ELEM_W-1:0] lane7;

  modport source (
    output valid, op, label_pos, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
    input  ready
  );
  modport sink (
    input  valid, op, label_pos, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
    output ready
  );
endinterface

/* hdl/svmhg_out_if.sv */
// svmhg_out_if: output channel carrying one scaled gradient element per word
// depends on svmhg_pkg
interface svmhg_out_if;
  import svmhg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [INDEX_W-1:0]       grad_index;
  logic signed [GRAD_W-1:0] grad_value;
  logic                     last;

  modport source (
    output valid, grad_index, grad_value, last,
    input  ready
  );
  modport sink (
    input  valid, grad_index, grad_value, last,
    output ready
  );
endinterface

/* hdl/svmhg_lane.sv */
// svmhg_lane: one feature lane: weight register, product register and
// saturating gradient accumulator; depends on svmhg_pkg
module svmhg_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  svmhg_pkg::lane_ctrl_t              ctrl_i,
  input  logic                               active_i,
  input  logic signed [svmhg_pkg::ELEM_W-1:0] x_i,
  output logic signed [svmhg_pkg::PROD_W-1:0] prod_o,
  output logic signed [svmhg_pkg::GRAD_W-1:0] grad_o
);
  import svmhg_pkg::*;

  localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

  logic signed [ELEM_W-1:0] weight_q;
  logic signed [ELEM_W-1:0] x_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [GRAD_W-1:0] grad_q, grad_d;
  logic signed [GRAD_W:0]   sum;

  // weight store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
    end else if (ctrl_i.load) begin
      weight_q <= x_i;
    end
  end

  // feature and product capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      x_q    <= x_i;
      prod_q <= PROD_W'(x_i) * PROD_W'(weight_q);
    end
  end

  // subtract y times feature, saturate to 32 bits
  always_comb begin
    if (ctrl_i.sub) begin
      sum = (GRAD_W+1)'(grad_q) - (GRAD_W+1)'(x_q);
    end else begin
      sum = (GRAD_W+1)'(grad_q) + (GRAD_W+1)'(x_q);
    end
    if (sum[GRAD_W] != sum[GRAD_W-1]) begin
      grad_d = sum[GRAD_W] ? GRAD_MIN : GRAD_MAX;
    end else begin
      grad_d = sum[GRAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_q <= '0;
    end else if (ctrl_i.clear) begin
      grad_q <= '0;
    end else if (ctrl_i.update && active_i) begin
      grad_q <= grad_d;
    end
  end

  assign prod_o = prod_q;
  assign grad_o = grad_q;

endmodule

/* hdl/svmhg_merge.sv */
// svmhg_merge: registered two-level adder tree over the lane products and
// the margin test against one; depends on svmhg_pkg
module svmhg_merge #(
  parameter int unsigned LIMIT     = 8,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic signed [svmhg_pkg::PROD_W-1:0] prod_i [LIMIT],
  input  logic [LIMIT-1:0]                    active_i,
  input  logic                                label_pos_i,
  output logic                                hit_o
);
  import svmhg_pkg::*;

  localparam int unsigned PAIRS = (LIMIT + 1) / 2;
  localparam logic signed [DOT_W-1:0] ONE     = DOT_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [DOT_W-1:0] NEG_ONE = -ONE;

  logic signed [PROD_W-1:0] masked [2*PAIRS];
  logic signed [PROD_W:0]   pairs_d [PAIRS];
  logic signed [PROD_W:0]   pairs_q [PAIRS];
  logic signed [DOT_W-1:0]  dot_d, dot_q;

  // mask unused lanes, pad to an even count
  always_comb begin
    for (int i = 0; i < 2 * PAIRS; i++) begin
      masked[i] = '0;
    end
    for (int i = 0; i < LIMIT; i++) begin
      masked[i] = active_i[i] ? prod_i[i] : '0;
    end
  end

  // first tree level
  always_comb begin
    for (int j = 0; j < PAIRS; j++) begin
      pairs_d[j] = (PROD_W+1)'(masked[2*j]) + (PROD_W+1)'(masked[2*j+1]);
    end
  end

  // second tree level
  always_comb begin
    dot_d = '0;
    for (int j = 0; j < PAIRS; j++) begin
      dot_d = dot_d + DOT_W'(pairs_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    pairs_q <= pairs_d;
    dot_q   <= dot_d;
  end

  // margin below one: y=+1 needs dot < one, y=-1 needs dot > -one
  assign hit_o = label_pos_i ? (dot_q < ONE) : (dot_q > NEG_ONE);

endmodule

/* hdl/svmhg_readout.sv */
// svmhg_readout: scales a gradient by twice lambda, floors, saturates and
// holds it in the output register; depends on svmhg_pkg and svmhg_out_if
module svmhg_readout (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svmhg_pkg::rd_ctrl_t                 ctrl_i,
  input  logic signed [svmhg_pkg::GRAD_W-1:0] grad_i,
  input  logic [svmhg_pkg::LAMBDA_W-1:0]      lambda_i,
  svmhg_out_if.source                         out_if
);
  import svmhg_pkg::*;

  localparam int unsigned MUL_W = GRAD_W + LAMBDA_W + 1;
  localparam int unsigned SCL_W = MUL_W - SCALE_SH;
  localparam logic signed [GRAD_W-1:0] VAL_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] VAL_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

  logic signed [MUL_W-1:0]  prod_q;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [GRAD_W-1:0] value_d;
  logic signed [GRAD_W-1:0] value_q;
  logic [INDEX_W-1:0]       index_q;
  logic                     last_q;
  logic                     valid_q;

  // g * lambda, 2*lambda*g = product / 2^15
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= MUL_W'(grad_i) * MUL_W'($signed({1'b0, lambda_i}));
    end
  end

  // arithmetic shift floors, then saturate
  always_comb begin
    scaled = prod_q[MUL_W-1:SCALE_SH];
    if (scaled[SCL_W-1:GRAD_W-1] == '0 || scaled[SCL_W-1:GRAD_W-1] == '1) begin
      value_d = scaled[GRAD_W-1:0];
    end else begin
      value_d = scaled[SCL_W-1] ? VAL_MIN : VAL_MAX;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      value_q <= value_d;
      index_q <= ctrl_i.index;
      last_q  <= ctrl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign out_if.valid      = valid_q;
  assign out_if.grad_value = value_q;
  assign out_if.grad_index = index_q;
  assign out_if.last       = last_q;

endmodule

/* hdl/svm_hinge_gradient_accumulator_core.sv */
// Hinge-loss gradient accumulator: lane-parallel products, registered adder tree,
// saturating per-lane accumulators. Load word: ready again next cycle.
// Sample word: accumulators update after the product, pair-sum and dot registers
// of the two-level adder tree; the next word is taken once the update is done.
// Read word: each gradient passes multiply, scale and output register in turn, and
// the next one starts once the sink takes the pending word. Reset is async.
module svm_hinge_gradient_accumulator_core #(
  parameter int unsigned FEATURES  = 8,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [svmhg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [svmhg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  svmhg_in_if.sink                             in_if,
  svmhg_out_if.source                          out_if
);
  import svmhg_pkg::*;

  localparam int unsigned LIMIT = (FEATURES < LANES) ? FEATURES : LANES;
  localparam int unsigned IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam logic [USED_W-1:0] LIMIT_N = USED_W'(LIMIT);

  logic [USED_W-1:0]        used_q;
  logic [LAMBDA_W-1:0]      lambda_q;
  logic [USED_W-1:0]        n_lanes;
  logic [LIMIT-1:0]         active;
  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     label_q;
  logic                     accept;
  logic                     hit;
  logic                     rd_last;
  op_e                      op;
  lane_ctrl_t               lane_ctrl;
  rd_ctrl_t                 rd_ctrl;
  logic signed [ELEM_W-1:0] in_lane [LANES];
  logic signed [PROD_W-1:0] prod_w [LIMIT];
  logic signed [GRAD_W-1:0] grad_w [LIMIT];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= USED_RESET;
      lambda_q <= LAMBDA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_USED_FEATURES: used_q   <= cfg_wdata_i[USED_W-1:0];
        CFG_LAMBDA:        lambda_q <= cfg_wdata_i[LAMBDA_W-1:0];
        default:           ;
      endcase
    end
  end

  // lanes in use, clamped to one .. lane limit
  always_comb begin
    if (used_q == '0) begin
      n_lanes = USED_W'(1);
    end else if (used_q > LIMIT_N) begin
      n_lanes = LIMIT_N;
    end else begin
      n_lanes = used_q;
    end
    for (int i = 0; i < LIMIT; i++) begin
      active[i] = USED_W'(i) < n_lanes;
    end
  end

  assign in_lane[0] = in_if.lane0;
  assign in_lane[1] = in_if.lane1;
  assign in_lane[2] = in_if.lane2;
  assign in_lane[3] = in_if.lane3;
  assign in_lane[4] = in_if.lane4;
  assign in_lane[5] = in_if.lane5;
  assign in_lane[6] = in_if.lane6;
  assign in_lane[7] = in_if.lane7;

  assign in_if.ready = (state_q == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign op          = op_e'(in_if.op);
  assign rd_last     = (USED_W'(idx_q) == n_lanes - USED_W'(1));

  // lane array
  for (genvar g = 0; g < LIMIT; g++) begin : g_lane
    svmhg_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .active_i (active[g]),
      .x_i      (in_lane[g]),
      .prod_o   (prod_w[g]),
      .grad_o   (grad_w[g])
    );
  end

  // dot product and margin test
  svmhg_merge #(
    .LIMIT     (LIMIT),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .prod_i      (prod_w),
    .active_i    (active),
    .label_pos_i (label_q),
    .hit_o       (hit)
  );

  // gradient scaling and output register
  svmhg_readout u_readout (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rd_ctrl),
    .grad_i   (grad_w[idx_q]),
    .lambda_i (lambda_q),
    .out_if   (out_if)
  );

  // label of the sample in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      label_q <= in_if.label_pos;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // next state and controls
  always_comb begin
    state_d           = state_q;
    idx_d             = idx_q;
    lane_ctrl         = '0;
    lane_ctrl.sub     = label_q;
    rd_ctrl           = '0;
    rd_ctrl.last      = rd_last;
    rd_ctrl.index     = INDEX_W'(idx_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD:   lane_ctrl.load = 1'b1;
            OP_SAMPLE: begin
              lane_ctrl.capture = 1'b1;
              state_d           = S_PAIR;
            end
            OP_READ: begin
              idx_d   = '0;
              state_d = S_RMUL;
            end
            default: ;
          endcase
        end
      end
      S_PAIR: state_d = S_DOT;
      S_DOT:  state_d = S_UPD;
      S_UPD: begin
        lane_ctrl.update = hit;
        state_d          = S_IDLE;
      end
      S_RMUL: begin
        rd_ctrl.mul = 1'b1;
        state_d     = S_RSAT;
      end
      S_RSAT: begin
        rd_ctrl.load    = 1'b1;
        lane_ctrl.clear = rd_last;
        state_d         = S_RWAIT;
      end
      S_RWAIT: begin
        if (out_if.ready) begin
          if (rd_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_RMUL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // no new word while a gradient word is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready)
    else $error("input ready while output word pending");

  // the final word of a readout carries the last lane in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.last) |-> (USED_W'(out_if.grad_index) == n_lanes - USED_W'(1)))
    else $error("last flag on wrong gradient index");

  // accumulators are clear once the final word is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RSAT && rd_last) |=> (grad_w[0] == '0))
    else $error("accumulator not cleared after readout");

  // an accepted sample enters the adder tree next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_SAMPLE) |=> (state_q == S_PAIR))
    else $error("sample not sequenced into the tree");

endmodule

/* dv/svm_hinge_gradient_accumulator_core_tb.sv */
// svm_hinge_gradient_accumulator_core_tb: directed table, full-scale run, back-pressure and
// random phases for the hinge-gradient accumulator, checked against a word-level predictor
// depends on svmhg_pkg, svmhg_in_if, svmhg_out_if and svm_hinge_gradient_accumulator_core
module svm_hinge_gradient_accumulator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svmhg_pkg::*;

  localparam int unsigned FEATURES    = 8;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned TAIL        = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 46;
  localparam int unsigned SAT_ROWS    = 10;
  localparam int unsigned DIR_N       = 23;
  localparam int unsigned MAX_SHOWN   = 10;

  localparam longint MARGIN_ONE = longint'(1) << (2 * FRAC_BITS);
  localparam longint GRAD_MAX   = 64'sd2147483647;
  localparam longint GRAD_MIN   = -64'sd2147483648;

  typedef struct packed {
    op_e                          op;
    logic                         label_pos;
    logic [LANES-1:0][ELEM_W-1:0] lane;
  } word_t;

  typedef struct packed {
    logic [INDEX_W-1:0]       index;
    logic signed [GRAD_W-1:0] value;
    logic                     last;
  } grad_t;

  typedef struct packed {
    word_t                    w;
    logic                     typed;
    logic signed [GRAD_W-1:0] value;
  } row_t;

  // directed words; typed value applies to every gradient of a read
  localparam row_t DIR_TAB [DIR_N] = '{
    '{'{OP_READ,   1'b0, {LANES{16'h0000}}}, 1'b1, 32'sd0},
    '{'{OP_SAMPLE, 1'b0, {LANES{16'h8000}}}, 1'b0, 32'sd0},
    '{'{OP_READ,   1'b0, {LANES{16'h0000}}}, 1'b1, -32'sd655},
    '{'{OP_READ,   1'b1, {LANES{16'hffff}}}, 1'b1, 32'sd0},
    '{'{OP_SAMPLE, 1'b1, {LANES{16'h7fff}}}, 1'b0, 32'sd0},
    '{'{OP_LOAD,   1'b0, {LANES{16'h7fff}}}, 1'b0, 32'sd0},
    '{'{OP_SAMPLE, 1'b1, {LANES{16'h7fff}}}, 1'b0, 32'sd0},
    '{'{OP_SAMPLE, 1'b0, {LANES{16'h7fff}}}, 1'b0, 32'sd0},
    '{'{OP_SAMPLE, 1'b1, {LANES{16'h8000}}}, 1'b0, 32'sd0},
    '{'{OP_NONE,   1'b1, {LANES{16'h5a5a}}}, 1'b0, 32'sd0},
    '{'{OP_READ,   1'b0, {LANES{16'h0000}}}, 1'b0, 32'sd0},
    // unit weight on lane 0 only, then margins at and just below one
    '{'{OP_LOAD,   1'b0, {{7{16'h0000}}, 16'h1000}}, 1'b0, 32'sd0},
    '{'{OP_SAMPLE, 1'b1, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h1234, 16'hedcb,
                          16'h7fff, 16'h1000}}, 1'b0, 32'sd0},
    '{'{OP_SAMPLE, 1'b1, {{7{16'h5a5a}}, 16'h0fff}}, 1'b0, 32'sd0},
    '{'{OP_SAMPLE, 1'b0, {{7{16'ha5a5}}, 16'hf000}}, 1'b0, 32'sd0},
    '{'{OP_SAMPLE, 1'b0, {{7{16'hffff}}, 16'hf001}}, 1'b0, 32'sd0},
    '{'{OP_READ,   1'b1, {LANES{16'h0000}}}, 1'b0, 32'sd0},
    '{'{OP_LOAD,   1'b1, {LANES{16'h8000}}}, 1'b0, 32'sd0},
    '{'{OP_SAMPLE, 1'b0, {LANES{16'h8000}}}, 1'b0, 32'sd0},
    '{'{OP_READ,   1'b0, {LANES{16'h0000}}}, 1'b1, -32'sd655},
    '{'{OP_LOAD,   1'b1, {LANES{16'h0000}}}, 1'b0, 32'sd0},
    '{'{OP_NONE,   1'b0, {LANES{16'hffff}}}, 1'b0, 32'sd0},
    '{'{OP_READ,   1'b1, {LANES{16'h0000}}}, 1'b1, 32'sd0}
  };

  // register settings per random phase, extremes included
  localparam logic [CFG_DATA_W-1:0] USED_PLAN [PHASES] = '{
    16'd8, 16'd1, 16'd0, 16'd15, 16'd3, 16'hfff5, 16'd6, 16'd8
  };
  localparam logic [CFG_DATA_W-1:0] LAMBDA_PLAN [PHASES] = '{
    16'd655, 16'd0, 16'hffff, 16'd1, 16'h8000, 16'd300, 16'd655, 16'd655
  };
  localparam int unsigned RAND_PHASE = 6;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  svmhg_in_if  in_ch ();
  svmhg_out_if out_ch ();

  svm_hinge_gradient_accumulator_core #(
    .FEATURES  (FEATURES),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // predictor state
  logic [USED_W-1:0]        cfg_used   = USED_RESET;
  logic [LAMBDA_W-1:0]      cfg_lambda = LAMBDA_RESET;
  logic signed [ELEM_W-1:0] weight_mirror [FEATURES];
  logic signed [GRAD_W-1:0] grad_mirror [FEATURES];
  grad_t                    fresh_q [$];
  grad_t                    grad_expect_q [$];

  // traffic shaping
  int tx_pct      = 0;
  int rx_pct      = 0;
  int hold_asked  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int mismatches  = 0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic signed [GRAD_W-1:0] sat32(input longint v);
    if (v > GRAD_MAX) return GRAD_MAX[GRAD_W-1:0];
    if (v < GRAD_MIN) return GRAD_MIN[GRAD_W-1:0];
    return v[GRAD_W-1:0];
  endfunction

  // zero acts as one, anything above the lane count clamps
  function automatic int lanes_used();
    int n;
    n = int'(cfg_used);
    if (n < 1) n = 1;
    if (n > int'(FEATURES)) n = int'(FEATURES);
    return n;
  endfunction

  // update the mirrored state for one word, gradients go to fresh_q
  function automatic void predict_word(input word_t w);
    int     n;
    longint dot;
    longint x;
    longint prod;
    n = lanes_used();
    case (w.op)
      OP_LOAD: begin
        for (int i = 0; i < int'(FEATURES); i++) weight_mirror[i] = $signed(w.lane[i]);
      end
      OP_SAMPLE: begin
        dot = 0;
        for (int i = 0; i < n; i++)
          dot += longint'($signed(w.lane[i])) * longint'(weight_mirror[i]);
        // hinge active only when label times dot is strictly below one
        if ((w.label_pos ? dot : -dot) < MARGIN_ONE) begin
          for (int i = 0; i < n; i++) begin
            x = longint'($signed(w.lane[i]));
            grad_mirror[i] = sat32(longint'(grad_mirror[i]) - (w.label_pos ? x : -x));
          end
        end
      end
      OP_READ: begin
        // 2 * lambda * g with lambda in Q0.16, floored
        for (int i = 0; i < n; i++) begin
          prod = longint'(grad_mirror[i]) * longint'(cfg_lambda);
          fresh_q.push_back('{index: INDEX_W'(i), value: sat32(prod >>> SCALE_SH),
                              last: (i == n - 1)});
        end
        foreach (grad_mirror[i]) grad_mirror[i] = '0;
      end
      default: ;
    endcase
  endfunction

  // element mix: full range, near unity, and the corners
  function automatic logic [ELEM_W-1:0] rand_elem();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return ELEM_W'($urandom);
    if (r < 80) return ELEM_W'($urandom_range(0, 16384)) - 16'd8192;
    case ($urandom_range(0, 3))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'h1000;
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t       w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)       w.op = OP_LOAD;
    else if (r < 78) w.op = OP_SAMPLE;
    else if (r < 94) w.op = OP_READ;
    else             w.op = OP_NONE;
    w.label_pos = 1'($urandom);
    for (int i = 0; i < int'(LANES); i++) w.lane[i] = rand_elem();
    return w;
  endfunction

  // offer one word, predict on acceptance
  task automatic send_word(input word_t w, input logic typed,
                           input logic signed [GRAD_W-1:0] typed_value);
    grad_t g;
    while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= w.op;
    in_ch.label_pos <= w.label_pos;
    in_ch.lane0     <= w.lane[0];
    in_ch.lane1     <= w.lane[1];
    in_ch.lane2     <= w.lane[2];
    in_ch.lane3     <= w.lane[3];
    in_ch.lane4     <= w.lane[4];
    in_ch.lane5     <= w.lane[5];
    in_ch.lane6     <= w.lane[6];
    in_ch.lane7     <= w.lane[7];
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    predict_word(w);
    while (fresh_q.size() != 0) begin
      g = fresh_q.pop_front();
      if (typed) g.value = typed_value;
      grad_expect_q.push_back(g);
    end
  endtask

  // stop offering until every gradient is back, then let a sample finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (grad_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] used_d,
                            input logic [CFG_DATA_W-1:0] lambda_d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_USED_FEATURES;
    cfg_wdata_i <= used_d;
    @(posedge clk_i);
    cfg_index_i <= CFG_LAMBDA;
    cfg_wdata_i <= lambda_d;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_used   = used_d[USED_W-1:0];
    cfg_lambda = lambda_d[LAMBDA_W-1:0];
  endtask

  // gradient sink: random stalls plus the long hold-off on request
  always @(posedge clk_i) begin
    if (hold_asked != hold_seen) begin
      hold_seen    <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  // compare each gradient word with the oldest prediction
  always @(posedge clk_i) begin : check_word
    grad_t got;
    grad_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{index: out_ch.grad_index, value: out_ch.grad_value, last: out_ch.last};
      if (grad_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected gradient word: index %0d value %0d last %0b",
                   got.index, got.value, got.last);
      end else begin
        want = grad_expect_q.pop_front();
        if (got.index !== want.index || got.value !== want.value || got.last !== want.last)
        begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("gradient mismatch: expected index %0d value %0d last %0b, got index %0d value %0d last %0b",
                     want.index, want.value, want.last, got.index, got.value, got.last);
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("svm_hinge_gradient_accumulator_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    word_t                 w;
    int unsigned           done_words;
    logic [CFG_DATA_W-1:0] used_d;
    logic [CFG_DATA_W-1:0] lambda_d;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_USED_FEATURES;
    cfg_wdata_i     = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_NONE;
    in_ch.label_pos = 1'b0;
    in_ch.lane0     = '0;
    in_ch.lane1     = '0;
    in_ch.lane2     = '0;
    in_ch.lane3     = '0;
    in_ch.lane4     = '0;
    in_ch.lane5     = '0;
    in_ch.lane6     = '0;
    in_ch.lane7     = '0;
    out_ch.ready    = 1'b0;
    foreach (weight_mirror[i]) begin
      weight_mirror[i] = '0;
      grad_mirror[i]   = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings
    for (int r = 0; r < int'(DIR_N); r++)
      send_word(DIR_TAB[r].w, DIR_TAB[r].typed, DIR_TAB[r].value);
    drain();

    // full-scale rows on zero weights: lanes 4-7 at the positive limit, 0-3 at the negative
    set_config(16'd8, 16'hffff);
    w.op        = OP_SAMPLE;
    w.label_pos = 1'b1;
    w.lane      = {{4{16'h7fff}}, {4{16'h8000}}};
    for (int k = 0; k < int'(SAT_ROWS); k++) send_word(w, 1'b0, '0);
    w.op = OP_READ;
    send_word(w, 1'b0, '0);
    drain();

    // sink holds off while reads keep coming, block must stall its input
    hold_asked <= hold_asked + 1;
    for (int k = 0; k < 24; k++) begin
      w = rand_word();
      if (k % 3 == 0) w.op = OP_READ;
      else if (w.op == OP_NONE) w.op = OP_SAMPLE;
      send_word(w, 1'b0, '0);
    end
    drain();

    // random phases, each with its own settings and traffic shape
    for (int p = 0; p < int'(PHASES); p++) begin
      used_d   = USED_PLAN[p];
      lambda_d = LAMBDA_PLAN[p];
      if (p == int'(RAND_PHASE)) begin
        used_d   = CFG_DATA_W'($urandom_range(2, 7));
        lambda_d = CFG_DATA_W'($urandom);
      end
      set_config(used_d, lambda_d);
      case (p % 4)
        0: begin
          tx_pct = 0;
          rx_pct <= 0;
        end
        1: begin
          tx_pct = 56;
          rx_pct <= 0;
        end
        2: begin
          tx_pct = 0;
          rx_pct <= 56;
        end
        default: begin
          tx_pct = 19;
          rx_pct <= 19;
        end
      endcase
      done_words = 0;
      while (done_words < PHASE_WORDS) begin
        w = rand_word();
        if ($urandom_range(0, 49) == 0) drain();
        send_word(w, 1'b0, '0);
        if (w.op != OP_NONE) done_words++;
      end
      drain();
    end

    repeat (TAIL) @(posedge clk_i);
    if (mismatches == 0 && grad_expect_q.size() == 0) begin
      $display("svm_hinge_gradient_accumulator_core_tb passed");
    end else begin
      $display("svm_hinge_gradient_accumulator_core_tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/svmhg_pkg.sv
hdl/svmhg_in_if.sv
hdl/svmhg_out_if.sv
hdl/svmhg_lane.sv
hdl/svmhg_merge.sv
hdl/svmhg_readout.sv
hdl/svm_hinge_gradient_accumulator_core.sv
dv/svm_hinge_gradient_accumulator_core_tb.sv
